// ===== hw/rtl/heap_block_allocator_defines.svh =====
`ifndef HEAP_BLOCK_ALLOCATOR_DEFINES_SVH
`define HEAP_BLOCK_ALLOCATOR_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define HBA_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define HBA_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== hw/rtl/hba_pkg.sv =====
`timescale 1ns / 1ps
package hba_pkg;

  localparam int unsigned BLOCK_HEADER_BYTES = 24;
  localparam int unsigned POOL_HEADER_BYTES  = 56;
  localparam int unsigned ALIGN_BYTES        = 16;
  localparam int unsigned QUEUE_DEPTH        = 2;
  localparam logic [31:0] POOL_RESET_BYTES   = 32'd65536;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NULL     = 3'd1;
  localparam logic [2:0] ST_NO_ROOM  = 3'd2;
  localparam logic [2:0] ST_BAD_PTR  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] request_bytes;
    logic [31:0] data_offset;
  } hba_in_t;

  typedef struct packed {
    logic [31:0] result_offset;
    logic [31:0] block_bytes;
    logic [2:0]  status;
    logic [31:0] used_bytes;
  } hba_out_t;

  typedef enum logic [1:0] {
    K_DONE,
    K_ALLOC,
    K_FIND
  } hba_kind_t;

  // Classified command as it waits for the back end.
  typedef struct packed {
    hba_kind_t   kind;
    logic        is_free;
    logic [2:0]  status;
    logic [31:0] size;
    logic [31:0] data;
  } hba_item_t;

  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] size;
    logic        freed;
  } hba_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_ADEC,
    S_FDEC,
    S_POP_RD,
    S_POP_CHK,
    S_RESP
  } hba_state_t;

  // Lower the break by one block, saturating at the pool start.
  function automatic logic [31:0] lower_break(input logic [31:0] brk,
                                              input logic [31:0] size);
    logic [32:0] amt;
    logic [33:0] diff;
    amt  = 33'(size) + 33'(BLOCK_HEADER_BYTES);
    diff = 34'(brk) - 34'(amt);
    if (!diff[33] && diff[32:0] >= 33'(POOL_HEADER_BYTES)) begin
      return diff[31:0];
    end
    return 32'(POOL_HEADER_BYTES);
  endfunction

endpackage

// ===== hw/rtl/heap_block_allocator.sv =====
`timescale 1ns / 1ps
// Block allocator over a pool kept as an address-ordered stack of blocks.
// Commands are classified on entry and queued (two deep), so new beats are
// taken while the back end works. The back end reads its block table one
// entry per cycle through a single memory read port: an allocate or lookup
// scans the table, then decides and responds; a free of the top block also
// pops each further trailing freed block, reading then checking it;
// commands rejected on entry go straight to the response. The result sits
// in an output register until taken. pool_bytes is to be written by the user
// only while no command is in flight; the block itself does not enforce it.
module heap_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hba_pkg::hba_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hba_pkg::hba_out_t out_data,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata
);
  import hba_pkg::*;

  `include "heap_block_allocator_defines.svh"

  logic [31:0] pool_r;
  hba_item_t   f_item, q_item;
  logic        q_full, q_empty, q_pop, push;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_r <= POOL_RESET_BYTES;
    end else if (cfg_we) begin
      pool_r <= cfg_wdata;
    end
  end

  hba_front u_front (
    .cmd_in     (in_data),
    .pool_bytes (pool_r),
    .item       (f_item)
  );

  hba_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  hba_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pool_bytes (pool_r),
    .q_empty    (q_empty),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  `HBA_ASSERT_SAME(a_err_no_offset, clk, rst_n, out_valid && out_data.status != ST_OK, out_data.result_offset == 32'd0, "error result carries an offset")
  `HBA_ASSERT_SAME(a_size_aligned, clk, rst_n, out_valid, (out_data.block_bytes & 32'(ALIGN_BYTES - 1)) == 32'd0, "block size not aligned")
  `HBA_ASSERT_NEXT(a_push_lands, clk, rst_n, push, !q_empty, "queued command lost")

endmodule

// ===== hw/rtl/hba_front.sv =====
`timescale 1ns / 1ps
module hba_front (
  input  hba_pkg::hba_in_t   cmd_in,
  input  logic [31:0]        pool_bytes,
  output hba_pkg::hba_item_t item
);
  import hba_pkg::*;

  logic [32:0] rounded;

  always_comb begin
    rounded = (33'(cmd_in.request_bytes) + 33'(ALIGN_BYTES - 1)) & ~33'(ALIGN_BYTES - 1);
    item.kind    = K_DONE;
    item.is_free = (cmd_in.command == CMD_FREE);
    item.status  = ST_OK;
    item.size    = rounded[31:0];
    item.data    = cmd_in.data_offset;
    case (cmd_in.command)
      CMD_ALLOC: begin
        if (cmd_in.request_bytes == 32'd0) begin
          item.status = ST_NULL;
        end else if (rounded[32]) begin
          item.status = ST_NO_ROOM;
        end else begin
          item.kind = K_ALLOC;
        end
      end
      CMD_FREE, CMD_QUERY: begin
        if (cmd_in.data_offset == 32'd0) begin
          item.status = ST_NULL;
        end else if (cmd_in.data_offset < 32'(POOL_HEADER_BYTES) ||
                     cmd_in.data_offset >= pool_bytes) begin
          item.status = ST_BAD_PTR;
        end else begin
          item.kind = K_FIND;
        end
      end
      default: begin
        item.status = ST_OK;
      end
    endcase
  end

endmodule

// ===== hw/rtl/hba_queue.sv =====
`timescale 1ns / 1ps
module hba_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hba_pkg::hba_item_t push_item,
  output logic               full,
  input  logic               pop,
  output hba_pkg::hba_item_t pop_item,
  output logic               empty
);
  import hba_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  hba_item_t      slot_r [QUEUE_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== hw/rtl/hba_back.sv =====
`timescale 1ns / 1ps
module hba_back #(
  parameter int unsigned MAX_BLOCKS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        pool_bytes,
  input  logic               q_empty,
  input  hba_pkg::hba_item_t q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output hba_pkg::hba_out_t  out_data
);
  import hba_pkg::*;

  localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);

  hba_entry_t mem [MAX_BLOCKS];
  hba_entry_t rd_q;
  logic       rd_en, mem_we;
  logic [IW-1:0] rd_addr, mem_wa;
  hba_entry_t mem_wd;

  hba_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, i_r, i_nxt;
  logic [31:0]   brk_r, brk_nxt, used_r, used_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;
  hba_item_t     item_r, item_nxt;
  logic          pick_vld_r, pick_vld_nxt;
  logic [IW-1:0] pick_idx_r, pick_idx_nxt;
  hba_entry_t    pick_r, pick_nxt;
  logic [31:0]   res_off_r, res_off_nxt, res_size_r, res_size_nxt;
  logic [2:0]    res_st_r, res_st_nxt;
  logic          out_valid_r, out_valid_nxt;
  hba_out_t      out_data_r, out_data_nxt;

  logic          fits, good, match;
  logic [34:0]   four_sz, five_req;
  logic [32:0]   need;
  logic [33:0]   end_at;
  logic [32:0]   amt;
  logic [CW-1:0] top;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    four_sz  = {1'b0, rd_q.size, 2'b00};
    five_req = {1'b0, item_r.size, 2'b00} + 35'(item_r.size);
    fits     = rd_q.freed && (rd_q.size >= item_r.size);
    good     = fits && (four_sz <= five_req);
    match    = (33'(rd_q.offset) + 33'(BLOCK_HEADER_BYTES)) == 33'(item_r.data);
    need     = 33'(item_r.size) + 33'(BLOCK_HEADER_BYTES);
    end_at   = 34'(brk_r) + 34'(need);
    amt      = 33'(pick_r.size) + 33'(BLOCK_HEADER_BYTES);
    top      = cnt_r - 1'b1;
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    i_nxt        = i_r;
    brk_nxt      = brk_r;
    used_nxt     = used_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = chk_idx_r;
    item_nxt     = item_r;
    pick_vld_nxt = pick_vld_r;
    pick_idx_nxt = pick_idx_r;
    pick_nxt     = pick_r;
    res_off_nxt  = res_off_r;
    res_size_nxt = res_size_r;
    res_st_nxt   = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt = out_data_r;
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = i_r[IW-1:0];
    mem_we       = 1'b0;
    mem_wa       = pick_idx_r;
    mem_wd       = pick_r;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          item_nxt     = q_item;
          i_nxt        = '0;
          pick_vld_nxt = 1'b0;
          res_off_nxt  = '0;
          res_size_nxt = '0;
          res_st_nxt   = q_item.status;
          state_nxt    = (q_item.kind == K_DONE) ? S_RESP : S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_vld_r && item_r.kind == K_ALLOC && good) begin
          pick_vld_nxt = 1'b1;
          pick_idx_nxt = chk_idx_r;
          pick_nxt     = rd_q;
          state_nxt    = S_ADEC;
        end else if (chk_vld_r && item_r.kind == K_FIND && match) begin
          pick_idx_nxt = chk_idx_r;
          pick_nxt     = rd_q;
          state_nxt    = S_FDEC;
        end else begin
          if (chk_vld_r && item_r.kind == K_ALLOC && fits &&
              (!pick_vld_r || rd_q.size < pick_r.size)) begin
            pick_vld_nxt = 1'b1;
            pick_idx_nxt = chk_idx_r;
            pick_nxt     = rd_q;
          end
          if (i_r < cnt_r) begin
            // issue the next read; its data is checked next cycle
            rd_en       = 1'b1;
            chk_vld_nxt = 1'b1;
            chk_idx_nxt = i_r[IW-1:0];
            i_nxt       = i_r + 1'b1;
          end else if (!chk_vld_r) begin
            if (item_r.kind == K_ALLOC) begin
              state_nxt = S_ADEC;
            end else begin
              res_st_nxt = ST_BAD_PTR;
              state_nxt  = S_RESP;
            end
          end
        end
      end
      S_ADEC: begin
        if (pick_vld_r) begin
          mem_we       = 1'b1;
          mem_wa       = pick_idx_r;
          mem_wd       = '{offset: pick_r.offset, size: pick_r.size, freed: 1'b0};
          used_nxt     = used_r + 32'(BLOCK_HEADER_BYTES) + pick_r.size;
          res_off_nxt  = pick_r.offset + 32'(BLOCK_HEADER_BYTES);
          res_size_nxt = pick_r.size;
        end else if (end_at > 34'(pool_bytes)) begin
          res_st_nxt = ST_NO_ROOM;
        end else if (cnt_r == CW'(MAX_BLOCKS)) begin
          res_st_nxt = ST_FULL;
        end else begin
          mem_we       = 1'b1;
          mem_wa       = cnt_r[IW-1:0];
          mem_wd       = '{offset: brk_r, size: item_r.size, freed: 1'b0};
          cnt_nxt      = cnt_r + 1'b1;
          res_off_nxt  = brk_r + 32'(BLOCK_HEADER_BYTES);
          res_size_nxt = item_r.size;
          brk_nxt      = end_at[31:0];
          used_nxt     = used_r + need[31:0];
        end
        state_nxt = S_RESP;
      end
      S_FDEC: begin
        state_nxt = S_RESP;
        if (!item_r.is_free) begin
          res_size_nxt = pick_r.size;
        end else begin
          if (!pick_r.freed) begin
            mem_we   = 1'b1;
            mem_wa   = pick_idx_r;
            mem_wd   = '{offset: pick_r.offset, size: pick_r.size, freed: 1'b1};
            used_nxt = (33'(used_r) >= amt) ? used_r - amt[31:0] : '0;
          end
          if (CW'(pick_idx_r) == top) begin
            // the freed block is the top one: drop it without a read
            cnt_nxt   = top;
            brk_nxt   = lower_break(brk_r, pick_r.size);
            state_nxt = S_POP_RD;
          end
        end
      end
      S_POP_RD: begin
        if (cnt_r == '0) begin
          state_nxt = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = top[IW-1:0];
          state_nxt = S_POP_CHK;
        end
      end
      S_POP_CHK: begin
        if (rd_q.freed) begin
          cnt_nxt   = top;
          brk_nxt   = lower_break(brk_r, rd_q.size);
          state_nxt = S_POP_RD;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{result_offset: res_off_r, block_bytes: res_size_r,
                            status: res_st_r, used_bytes: used_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      brk_r       <= 32'(POOL_HEADER_BYTES);
      used_r      <= '0;
      chk_vld_r   <= 1'b0;
      pick_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      brk_r       <= brk_nxt;
      used_r      <= used_nxt;
      chk_vld_r   <= chk_vld_nxt;
      pick_vld_r  <= pick_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    chk_idx_r  <= chk_idx_nxt;
    item_r     <= item_nxt;
    pick_idx_r <= pick_idx_nxt;
    pick_r     <= pick_nxt;
    res_off_r  <= res_off_nxt;
    res_size_r <= res_size_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

endmodule
